// ===== sv/rsmst_pkg.sv =====
// Shared types and constants for the range sum / range minimum segment tree.
// Holds operation codes, the controller command and status structs and the
// signed minimum helper. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rsmst_pkg;

	// Fixed widths of the item fields.
	localparam int DATA_W  = 32;
	localparam int FIELD_W = 11;
	localparam int FUNC_W  = 2;

	// Operation codes carried on func.
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SUM    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MIN    = 2'd2;

	// Minimum over an empty range.
	localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // latch the accepted item
		logic clr_wr;   // write zero at the clear pointer
		logic leaf_wr;  // write the leaf, read its sibling
		logic up_step;  // write the parent, climb one level, read next sibling
		logic rd_lo;    // read node at the low end, advance it
		logic rd_hi;    // step the high end back, read that node
		logic acc_en;   // fold the read node into the accumulator
		logic shift;    // move both query ends up one level
		logic finish;   // register the result and pulse done
	} rsmst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_upd;
		logic is_query;
		logic bad;
		logic lo_lt_hi;
		logic lo_odd;
		logic hi_odd;
		logic k_is_root;
		logic parent_is_root;
		logic clr_last;
	} rsmst_stat_t;

	// Signed minimum of two 32-bit values.
	function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		smin = ($signed(a) <= $signed(b)) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/range_sum_min_segment_tree_top.sv =====
// Range sum / range minimum segment tree. After reset all 2*MAX_LEAVES
// node store entries are swept to zero with busy high; config still works.
// Update: the leaf is written, then the climb rewrites one tree level per
// cycle, since it writes a parent and reads the next sibling together.
// Query: each tree level passes through a test and, where needed, a low-end
// read and a high-end read in turn, since one node is read at a time.
// One item at a time; done pulses one cycle and the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module range_sum_min_segment_tree_top
	import rsmst_pkg::*;
#(
	parameter int MAX_LEAVES = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [FIELD_W-1:0]       cfg_wdata,
	input  wire logic                     start,
	output      logic                     busy,
	input  wire logic [FUNC_W-1:0]        func,
	input  wire logic [FIELD_W-1:0]       left_index,
	input  wire logic [FIELD_W-1:0]       right_end,
	input  wire logic signed [DATA_W-1:0] new_value,
	output      logic                     done,
	output      logic signed [DATA_W-1:0] answer,
	output      logic                     empty_range,
	output      logic                     bad_index
);

	rsmst_cmd_t  cmd;
	rsmst_stat_t st;

	// Controller.
	rsmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	rsmst_dp #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.func        (func),
		.left_index  (left_index),
		.right_end   (right_end),
		.new_value   (new_value),
		.answer      (answer),
		.empty_range (empty_range),
		.bad_index   (bad_index),
		.done        (done)
	);

`ifndef NO_ASSERTIONS
	// A result only follows a cycle in which the block was working.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding busy cycle");

	// An accepted item keeps the block busy and gives no result at once.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not make the block busy");

	// A rejected index gives a zero answer and no empty flag.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_index) |-> ((answer == '0) && !empty_range))
		else $error("bad index result carries data");

	// The empty flag and the bad-index flag never come together.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && empty_range) |-> !bad_index)
		else $error("empty and bad index flags both set");
`endif

endmodule

`default_nettype wire

// ===== sv/rsmst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for both node stores of the segment tree. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rsmst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/rsmst_ctrl.sv =====
// Controller state machine of the segment tree: clear sweep, update climb
// and query walk. Depends on rsmst_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rsmst_ctrl
	import rsmst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire rsmst_stat_t st,
	output      rsmst_cmd_t  cmd,
	output      logic        busy
);

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_CHECK   = 3'd2;
	localparam logic [2:0] S_U_CLIMB = 3'd3;
	localparam logic [2:0] S_Q_TEST  = 3'd4;
	localparam logic [2:0] S_Q_LO    = 3'd5;
	localparam logic [2:0] S_Q_HI    = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// State register; reset starts the clear sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.bad || !(st.is_upd || st.is_query)) begin
					state_d = S_DONE;
				end else if (st.is_upd) begin
					cmd.leaf_wr = 1'b1;
					state_d     = st.k_is_root ? S_DONE : S_U_CLIMB;
				end else begin
					state_d = S_Q_TEST;
				end
			end
			S_U_CLIMB: begin
				cmd.up_step = 1'b1;
				if (st.parent_is_root) begin
					state_d = S_DONE;
				end
			end
			S_Q_TEST: begin
				if (!st.lo_lt_hi) begin
					state_d = S_DONE;
				end else if (st.lo_odd) begin
					cmd.rd_lo = 1'b1;
					state_d   = S_Q_LO;
				end else if (st.hi_odd) begin
					cmd.rd_hi = 1'b1;
					state_d   = S_Q_HI;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_Q_LO: begin
				// The high end is tested after the low end has moved.
				cmd.acc_en = 1'b1;
				if (st.hi_odd) begin
					cmd.rd_hi = 1'b1;
					state_d   = S_Q_HI;
				end else begin
					cmd.shift = 1'b1;
					state_d   = S_Q_TEST;
				end
			end
			S_Q_HI: begin
				cmd.acc_en = 1'b1;
				cmd.shift  = 1'b1;
				state_d    = S_Q_TEST;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/rsmst_dp.sv =====
// Datapath of the segment tree: leaf count register, node stores, index and
// accumulator registers and the result registers. Depends on rsmst_pkg and
// instantiates rsmst_ram for the sum and minimum node stores.
`timescale 1ns / 1ps
`default_nettype none

module rsmst_dp
	import rsmst_pkg::*;
#(
	parameter int MAX_LEAVES = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rsmst_cmd_t               cmd,
	output      rsmst_stat_t              st,
	input  wire logic                     cfg_we,
	input  wire logic [FIELD_W-1:0]       cfg_wdata,
	input  wire logic [FUNC_W-1:0]        func,
	input  wire logic [FIELD_W-1:0]       left_index,
	input  wire logic [FIELD_W-1:0]       right_end,
	input  wire logic signed [DATA_W-1:0] new_value,
	output      logic signed [DATA_W-1:0] answer,
	output      logic                     empty_range,
	output      logic                     bad_index,
	output      logic                     done
);

	localparam int NODES = 2 * MAX_LEAVES;
	localparam int AW    = $clog2(NODES);
	localparam int KW    = AW + 1;
	localparam int NL    = $clog2(MAX_LEAVES + 1);
	localparam int CW    = (NL > FIELD_W) ? NL : FIELD_W;

	logic [NL-1:0]     n_q;
	logic [AW-1:0]     clr_q;
	logic [FUNC_W-1:0] func_q;
	logic [KW-1:0]     lo_q;
	logic [KW-1:0]     hi_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] cur_sum_q;
	logic [DATA_W-1:0] cur_min_q;
	logic              bad_q;
	logic              empty_q;

	logic [CW-1:0]     cfg_ext;
	logic [CW-1:0]     n_ext;
	logic [CW-1:0]     lo_ext;
	logic [CW-1:0]     hi_ext;
	logic [CW:0]       lo_node;
	logic [CW:0]       hi_node;
	logic              in_upd;
	logic              in_query;
	logic              in_bad;
	logic              q_upd;
	logic              q_query;
	logic              want_min;

	logic [KW-1:0]     parent;
	logic [KW-1:0]     hi_dec;
	logic [KW-1:0]     raddr_full;
	logic [KW-1:0]     waddr_full;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] sum_wdata;
	logic [DATA_W-1:0] min_wdata;
	logic [DATA_W-1:0] sum_rdata;
	logic [DATA_W-1:0] min_rdata;
	logic [DATA_W-1:0] sum_up;
	logic [DATA_W-1:0] min_up;
	logic [DATA_W-1:0] tree_rdata;

	// Leaf count register; writes of zero or above the maximum are clamped.
	assign cfg_ext = CW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NL'(MAX_LEAVES);
		end else if (cfg_we) begin
			if (cfg_ext == '0) begin
				n_q <= NL'(1);
			end else if (cfg_ext > CW'(MAX_LEAVES)) begin
				n_q <= NL'(MAX_LEAVES);
			end else begin
				n_q <= NL'(cfg_ext);
			end
		end
	end

	// Clear pointer for the sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Index checks on the incoming item.
	assign n_ext    = CW'(n_q);
	assign lo_ext   = CW'(left_index);
	assign hi_ext   = CW'(right_end);
	assign lo_node  = {1'b0, lo_ext} + {1'b0, n_ext};
	assign hi_node  = {1'b0, hi_ext} + {1'b0, n_ext};
	assign in_upd   = (func == FUNC_UPDATE);
	assign in_query = (func == FUNC_SUM) || (func == FUNC_MIN);
	assign in_bad   = (in_upd && (lo_ext >= n_ext)) ||
		(in_query && ((lo_ext > n_ext) || (hi_ext > n_ext)));

	// Item registers: operation, flags and the two tree positions.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			bad_q   <= in_bad;
			empty_q <= in_query && !in_bad && (lo_ext >= hi_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= KW'(lo_node);
		end else if (cmd.up_step) begin
			lo_q <= parent;
		end else if (cmd.rd_lo) begin
			lo_q <= lo_q + KW'(1);
		end else if (cmd.shift) begin
			lo_q <= lo_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q <= KW'(hi_node);
		end else if (cmd.rd_hi) begin
			hi_q <= hi_dec;
		end else if (cmd.shift) begin
			hi_q <= hi_q >> 1;
		end
	end

	assign q_upd    = (func_q == FUNC_UPDATE);
	assign q_query  = (func_q == FUNC_SUM) || (func_q == FUNC_MIN);
	assign want_min = (func_q == FUNC_MIN);
	assign parent   = lo_q >> 1;
	assign hi_dec   = hi_q - KW'(1);

	// Node store addressing: the update climb reads the sibling of the node
	// it writes, the query reads one end of the range.
	always_comb begin
		if (cmd.rd_hi) begin
			raddr_full = hi_dec;
		end else if (cmd.rd_lo) begin
			raddr_full = lo_q;
		end else if (cmd.up_step) begin
			raddr_full = parent ^ KW'(1);
		end else begin
			raddr_full = lo_q ^ KW'(1);
		end
	end

	assign waddr_full = cmd.leaf_wr ? lo_q : parent;
	assign ram_raddr  = raddr_full[AW-1:0];
	assign ram_waddr  = cmd.clr_wr ? clr_q : waddr_full[AW-1:0];
	assign ram_we     = cmd.clr_wr || cmd.leaf_wr || cmd.up_step;

	// Parent values from the node just written and its sibling.
	assign sum_up = cur_sum_q + sum_rdata;
	assign min_up = smin(cur_min_q, min_rdata);

	always_comb begin
		if (cmd.clr_wr) begin
			sum_wdata = '0;
			min_wdata = '0;
		end else if (cmd.leaf_wr) begin
			sum_wdata = cur_sum_q;
			min_wdata = cur_min_q;
		end else begin
			sum_wdata = sum_up;
			min_wdata = min_up;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_sum_q <= new_value;
			cur_min_q <= new_value;
		end else if (cmd.up_step) begin
			cur_sum_q <= sum_up;
			cur_min_q <= min_up;
		end
	end

	rsmst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NODES)
	) u_sum_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sum_wdata),
		.raddr (ram_raddr),
		.rdata (sum_rdata)
	);

	rsmst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NODES)
	) u_min_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (min_wdata),
		.raddr (ram_raddr),
		.rdata (min_rdata)
	);

	// Query accumulator.
	assign tree_rdata = want_min ? min_rdata : sum_rdata;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= (func == FUNC_MIN) ? INT_MAX : '0;
		end else if (cmd.acc_en) begin
			acc_q <= want_min ? smin(acc_q, tree_rdata) : acc_q + tree_rdata;
		end
	end

	// Result registers; done marks the one-cycle transfer.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			answer      <= (q_query && !bad_q) ? acc_q : '0;
			empty_range <= empty_q;
			bad_index   <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	// Status to the controller.
	assign st.is_upd         = q_upd;
	assign st.is_query       = q_query;
	assign st.bad            = bad_q;
	assign st.lo_lt_hi       = (lo_q < hi_q);
	assign st.lo_odd         = lo_q[0];
	assign st.hi_odd         = hi_q[0];
	assign st.k_is_root      = (lo_q == KW'(1));
	assign st.parent_is_root = (lo_q[KW-1:1] == (KW-1)'(1));
	assign st.clr_last       = (clr_q == AW'(NODES - 1));

endmodule

`default_nettype wire

// ===== dv/range_sum_min_segment_tree_checker.sv =====
// Checker for the range sum / range minimum segment tree: watches the config,
// command and result ports, predicts every result and compares field by field.
// Depends on rsmst_pkg for widths and operation codes.
`timescale 1ns / 1ps

module range_sum_min_segment_tree_checker
	import rsmst_pkg::*;
#(
	parameter int MAX_LEAVES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [FIELD_W-1:0] cfg_wdata,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [FIELD_W-1:0] left_index,
	input  wire logic [FIELD_W-1:0] right_end,
	input  wire logic [DATA_W-1:0]  new_value,
	input  wire logic               done,
	input  wire logic [DATA_W-1:0]  answer,
	input  wire logic               empty_range,
	input  wire logic               bad_index,
	output int                      mismatches,
	output int                      pending,
	output int                      checked,
	output int                      bad_seen,
	output int                      empty_seen
);

	localparam int NODES = 2 * MAX_LEAVES;
	localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;
	localparam int REPORT_LIMIT = 10;

	// One predicted result, with the command that caused it for reporting.
	typedef struct packed {
		logic [FUNC_W-1:0]  op;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic [DATA_W-1:0]  answer;
		logic               empty;
		logic               bad;
	} outcome_t;

	// Shadow copy of both trees and the tree size.
	logic [DATA_W-1:0] sum_tree [NODES];
	logic [DATA_W-1:0] min_tree [NODES];
	int unsigned       leaves;
	outcome_t          expected_q [$];

	// Flipping the sign bits lets an unsigned compare order signed values.
	function automatic logic [DATA_W-1:0] lower_of(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		return ((a ^ SIGN_BIT) <= (b ^ SIGN_BIT)) ? a : b;
	endfunction

	function automatic logic [DATA_W-1:0] read_node(input bit from_min, input int unsigned k);
		if (k >= NODES)
			return '0;
		return from_min ? min_tree[k] : sum_tree[k];
	endfunction

	// Write one leaf and rebuild its ancestors in both trees.
	function automatic void store_leaf(input int unsigned idx, input logic [DATA_W-1:0] v);
		int unsigned k;
		int unsigned p;
		k = idx + leaves;
		if (k >= NODES)
			return;
		sum_tree[k] = v;
		min_tree[k] = v;
		while (k > 1) begin
			p = k >> 1;
			sum_tree[p] = read_node(1'b0, k) + read_node(1'b0, k ^ 1);
			min_tree[p] = lower_of(read_node(1'b1, 2 * p), read_node(1'b1, 2 * p + 1));
			k = p;
		end
	endfunction

	// Climb both ends of [lo, hi) toward the root, folding in the nodes left behind.
	function automatic logic [DATA_W-1:0] fold_range(input bit want_min,
			input int unsigned lo, input int unsigned hi);
		logic [DATA_W-1:0] acc;
		acc = want_min ? INT_MAX : '0;
		lo += leaves;
		hi += leaves;
		while (lo < hi) begin
			if (lo[0]) begin
				acc = want_min ? lower_of(acc, read_node(1'b1, lo)) : acc + read_node(1'b0, lo);
				lo++;
			end
			if (hi[0]) begin
				hi--;
				acc = want_min ? lower_of(acc, read_node(1'b1, hi)) : acc + read_node(1'b0, hi);
			end
			lo >>= 1;
			hi >>= 1;
		end
		return acc;
	endfunction

	// Work out the result of one command and apply its effect on the trees.
	function automatic outcome_t predict(input logic [FUNC_W-1:0] op,
			input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi,
			input logic [DATA_W-1:0] v);
		outcome_t r;
		r    = '0;
		r.op = op;
		r.lo = lo;
		r.hi = hi;
		case (op)
			FUNC_UPDATE: begin
				if (lo >= leaves)
					r.bad = 1'b1;
				else
					store_leaf(lo, v);
			end
			FUNC_SUM, FUNC_MIN: begin
				if (lo > leaves || hi > leaves) begin
					r.bad = 1'b1;
				end else begin
					r.empty  = (lo >= hi);
					r.answer = fold_range(op == FUNC_MIN, lo, hi);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Register writes, result checks and command transfers, in that order, so a
	// result finishing at the same edge as the next transfer meets its own entry.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			leaves = MAX_LEAVES;
			for (int i = 0; i < NODES; i++) begin
				sum_tree[i] = '0;
				min_tree[i] = '0;
			end
			expected_q.delete();
			mismatches = 0;
			pending    = 0;
			checked    = 0;
			bad_seen   = 0;
			empty_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_wdata == 0)
					leaves = 1;
				else if (cfg_wdata > MAX_LEAVES)
					leaves = MAX_LEAVES;
				else
					leaves = cfg_wdata;
			end
			if (done) begin
				checked++;
				if (bad_index)
					bad_seen++;
				if (empty_range)
					empty_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with nothing pending: answer %0d empty %0b bad %0b",
							$realtime, $signed(answer), empty_range, bad_index);
				end else begin
					want = expected_q.pop_front();
					if (answer !== want.answer || empty_range !== want.empty ||
							bad_index !== want.bad) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"%0t: func %0d [%0d,%0d): expected answer %0d empty %0b ",
								"bad %0b, got answer %0d empty %0b bad %0b"},
								$realtime, want.op, want.lo, want.hi, $signed(want.answer),
								want.empty, want.bad, $signed(answer), empty_range, bad_index);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict(func, left_index, right_end, new_value));
			pending = expected_q.size();
		end
	end

endmodule

// ===== dv/tb_range_sum_min_segment_tree_top.sv =====
// Testbench top for the range sum / range minimum segment tree: drives
// directed and random commands over several tree sizes and gives the verdict.
// Depends on rsmst_pkg, the block and range_sum_min_segment_tree_checker.
`timescale 1ns / 1ps

module tb_range_sum_min_segment_tree_top
	import rsmst_pkg::*;
();

	localparam int MAX_LEAVES = 1024;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 165;
	// Slowest run: about 2000 items, each with its block time and longest gap,
	// plus the clearing sweep and the drains; this limit is several times that.
	localparam int LIMIT_CYCLES = 1_000_000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [FIELD_W-1:0]       cfg_wdata;
	logic                     start;
	logic                     busy;
	logic [FUNC_W-1:0]        func;
	logic [FIELD_W-1:0]       left_index;
	logic [FIELD_W-1:0]       right_end;
	logic signed [DATA_W-1:0] new_value;
	logic                     done;
	logic signed [DATA_W-1:0] answer;
	logic                     empty_range;
	logic                     bad_index;

	int mismatches;
	int pending;
	int checked;
	int bad_seen;
	int empty_seen;
	int items_sent;
	int sizes_used;
	int cycle_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	range_sum_min_segment_tree_top #(
		.MAX_LEAVES(MAX_LEAVES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.left_index (left_index),
		.right_end  (right_end),
		.new_value  (new_value),
		.done       (done),
		.answer     (answer),
		.empty_range(empty_range),
		.bad_index  (bad_index)
	);

	range_sum_min_segment_tree_checker #(
		.MAX_LEAVES(MAX_LEAVES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.left_index (left_index),
		.right_end  (right_end),
		.new_value  (new_value),
		.done       (done),
		.answer     (answer),
		.empty_range(empty_range),
		.bad_index  (bad_index),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.bad_seen   (bad_seen),
		.empty_seen (empty_seen)
	);

	// Present one command and hold it until the block takes it.
	task automatic send_op(input logic [FUNC_W-1:0] f, input logic [FIELD_W-1:0] lo,
			input logic [FIELD_W-1:0] hi, input logic [DATA_W-1:0] v);
		@(negedge clk);
		start      <= 1'b1;
		func       <= f;
		left_index <= lo;
		right_end  <= hi;
		new_value  <= v;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		items_sent++;
	endtask

	task automatic pause(input int unsigned cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Hold off until every transfer has produced its result.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_leaf_count(input logic [FIELD_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sizes_used++;
	endtask

	// Values lean toward extremes and small numbers so sums and minima move.
	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return MOST_NEG;
		if (pick < 6)
			return INT_MAX;
		if (pick < 9)
			return ALL_ONES;
		if (pick < 40)
			return DATA_W'($urandom_range(0, 200)) - 32'd100;
		return $urandom();
	endfunction

	// Mostly valid updates and queries on a tree of n leaves; some bad
	// indices and the unused selector as noise.
	task automatic send_random(input int unsigned n);
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		logic [FUNC_W-1:0] f;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_op(FUNC_UPDATE, FIELD_W'($urandom_range(0, n - 1)),
				FIELD_W'($urandom()), pick_value());
		end else if (pick < 88) begin
			f  = (pick < 64) ? FUNC_SUM : FUNC_MIN;
			lo = $urandom_range(0, n);
			hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lo) : $urandom_range(lo, n);
			send_op(f, FIELD_W'(lo), FIELD_W'(hi), $urandom());
		end else if (pick < 97) begin
			case ($urandom_range(0, 2))
				0: send_op(FUNC_UPDATE, FIELD_W'($urandom_range(n, FIELD_MAX)),
					FIELD_W'($urandom()), pick_value());
				1: send_op(FUNC_SUM, FIELD_W'($urandom_range(n + 1, FIELD_MAX)),
					FIELD_W'($urandom()), $urandom());
				default: send_op(FUNC_MIN, FIELD_W'($urandom()),
					FIELD_W'($urandom_range(n + 1, FIELD_MAX)), $urandom());
			endcase
		end else begin
			send_op(FUNC_UNUSED, FIELD_W'($urandom()), FIELD_W'($urandom()), $urandom());
		end
	endtask

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_range_sum_min_segment_tree_top NOT OK");
		$finish;
	end

	initial begin
		int          leaf_settings [PHASES];
		int unsigned n;
		bit          steady;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		start      = 1'b0;
		func       = FUNC_UPDATE;
		left_index = '0;
		right_end  = '0;
		new_value  = '0;
		items_sent = 0;
		sizes_used = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Full-size tree: field extremes, every operation and each corner.
		write_leaf_count(FIELD_W'(MAX_LEAVES));
		send_op(FUNC_UPDATE, 0, 0, MOST_NEG);
		send_op(FUNC_UPDATE, 1023, 0, INT_MAX);
		send_op(FUNC_UPDATE, 1, FIELD_MAX, INT_MAX);
		pause(gap_len());
		send_op(FUNC_UPDATE, 2, 0, INT_MAX);
		send_op(FUNC_UPDATE, 1024, 0, ALL_ONES);
		send_op(FUNC_UPDATE, FIELD_MAX, 0, 32'h1234_5678);
		send_op(FUNC_SUM, 0, 1024, 0);
		send_op(FUNC_MIN, 0, 1024, 0);
		pause(gap_len());
		send_op(FUNC_SUM, 1, 3, 0);
		send_op(FUNC_MIN, 1023, 1024, 0);
		send_op(FUNC_SUM, 5, 5, 0);
		send_op(FUNC_MIN, 7, 3, 0);
		send_op(FUNC_SUM, 1024, 1024, 0);
		send_op(FUNC_MIN, 0, 1025, 0);
		send_op(FUNC_SUM, 1025, 3, 0);
		send_op(FUNC_MIN, FIELD_MAX, FIELD_MAX, ALL_ONES);
		send_op(FUNC_UNUSED, FIELD_MAX, FIELD_MAX, ALL_ONES);
		send_op(FUNC_UNUSED, 0, 0, 0);
		send_op(FUNC_MIN, 1, 2, 0);

		// Random phases, each at its own tree size; zero and all-ones
		// writes check the clamping of the size register.
		leaf_settings = '{0, 2, 2047, 3, 1, 1500, 17, 1023, 64, 5, 0, 0};
		leaf_settings[10] = $urandom_range(1, MAX_LEAVES);
		leaf_settings[11] = $urandom_range(1, MAX_LEAVES);
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_leaf_count(FIELD_W'(leaf_settings[ph]));
			if (leaf_settings[ph] == 0)
				n = 1;
			else if (leaf_settings[ph] > MAX_LEAVES)
				n = MAX_LEAVES;
			else
				n = leaf_settings[ph];
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random(n);
				if ($urandom_range(0, 199) == 0)
					drain();
				else if (!steady)
					pause(gap_len());
			end
		end

		drain();
		repeat (50) @(negedge clk);

		$display("Run covered %0d transfers over %0d leaf-count settings.",
			items_sent, sizes_used);
		$display("%0d results checked: %0d flagged a bad index, %0d an empty range.",
			checked, bad_seen, empty_seen);
		if (mismatches == 0 && pending == 0)
			$display("tb_range_sum_min_segment_tree_top OK");
		else
			$display("tb_range_sum_min_segment_tree_top NOT OK");
		$finish;
	end

endmodule
